// ----- sv/sampled_table_linear_interp_defines.svh -----
// assertion macros for the interpolation table block
`ifndef SAMPLED_TABLE_LINEAR_INTERP_DEFINES_SVH
`define SAMPLED_TABLE_LINEAR_INTERP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define STLI_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define STLI_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/stli_pkg.sv -----
// shared constants and types for the interpolation table block
`default_nettype none

package stli_pkg;

    localparam int DEF_TABLE_DEPTH  = 1024;
    localparam int DEF_VALUE_BITS   = 32;

    localparam int FIELD_BITS       = 32;
    localparam int INDEX_BITS       = 10;
    localparam int COUNT_BITS       = 11;
    localparam int STATUS_BITS      = 2;

    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 1;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << WEIGHT_FRAC_BITS;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_BELOW = 2'd1,
        ST_ABOVE = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ----- sv/stli_if.sv -----
// valid/ready channel interfaces for items and results
`default_nettype none

interface stli_in_if import stli_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [INDEX_BITS-1:0] entry_index;
    logic [FIELD_BITS-1:0] point_x;
    logic [FIELD_BITS-1:0] point_y;

    modport source (output valid, opcode, entry_index, point_x, point_y, input ready);
    modport sink   (input valid, opcode, entry_index, point_x, point_y, output ready);
endinterface

interface stli_out_if import stli_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FIELD_BITS-1:0]  interpolated_value;
    logic [INDEX_BITS-1:0]  lower_index;
    logic [STATUS_BITS-1:0] status;

    modport source (output valid, interpolated_value, lower_index, status, input ready);
    modport sink   (input valid, interpolated_value, lower_index, status, output ready);
endinterface

`default_nettype wire

// ----- sv/sampled_table_linear_interp.sv -----
// top level: sample table with binary search, serial weight divide and interpolation
//
//  channel      dir  kind                payload
//  item_in      in   valid/ready         opcode, entry_index, point_x, point_y
//  result_out   out  valid/ready         interpolated_value, lower_index, status
//  cfg_wr_*     in   write enable/data   entries_in_use
//
//  one item in work at a time; the next item is taken while a result waits in the output register
//  load: the table write happens at the transfer itself
//  query: the search loop spends a search and a wait state on each probe for the registered
//    read of the x memory; the divider produces the 16 weight bits and is skipped when the
//    weight is 0 or 1.0
//  reset clears the controller, the output valid and entries_in_use; table contents are
//    undefined until loaded, so there is no clearing pass
//  a stalled result_out holds the finished result; a further finished result keeps the block busy until it drains
`default_nettype none
`include "sampled_table_linear_interp_defines.svh"

module sampled_table_linear_interp import stli_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [COUNT_BITS-1:0] cfg_wr_data,
    stli_in_if.sink                    item_in,
    stli_out_if.source                 result_out
);

    // widths above the field width act as the field width
    localparam int VB = (VALUE_BITS > FIELD_BITS) ? FIELD_BITS : VALUE_BITS;
    localparam int DW = VB + 1;                              // differences
    localparam int PW = WEIGHT_BITS + 1 + DW;                // weight times dy
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = (AW > COUNT_BITS) ? AW : COUNT_BITS; // search index width
    localparam logic [IW:0] DEPTH_C = (IW+1)'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SWAIT,
        S_CHECK,
        S_RD1,
        S_RD2,
        S_WEIGHT,
        S_DIV,
        S_MUL,
        S_ADD,
        S_FINISH
    } state_t;

    state_t                 state_reg;
    logic                   out_valid_reg;
    logic [FIELD_BITS-1:0]  out_value_reg;
    logic [INDEX_BITS-1:0]  out_index_reg;
    status_t                out_status_reg;
    logic [COUNT_BITS-1:0]  entries_reg;

    // query datapath
    logic signed [VB-1:0]   px_reg;
    logic [IW-1:0]          n_reg;
    logic [IW-1:0]          lo_reg;
    logic [IW-1:0]          count_reg;
    logic [IW-1:0]          m_reg;
    logic [IW-1:0]          step_reg;
    logic [IW-1:0]          k_reg;
    logic signed [VB-1:0]   x0_reg;
    logic signed [VB-1:0]   y0_reg;
    logic signed [DW-1:0]   dx_reg;
    logic signed [DW-1:0]   num_reg;
    logic signed [DW-1:0]   dy_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic signed [PW-1:0]   prod_reg;
    logic [FIELD_BITS-1:0]  res_value_reg;
    logic [INDEX_BITS-1:0]  res_index_reg;
    status_t                res_status_reg;

    logic                   in_xfer;
    logic                   out_free;
    logic [IW-1:0]          idx_w;
    logic                   idx_ok;
    logic                   tbl_wr;
    logic [IW:0]            eiu_w;
    logic [IW:0]            n_full;
    logic [IW-1:0]          m_sum;
    logic [IW-1:0]          lo_dec;
    logic [IW-1:0]          k_inc;
    logic [AW-1:0]          rd_addr;
    logic [VB-1:0]          x_rdata;
    logic [VB-1:0]          y_rdata;
    logic                   x_le;
    logic                   w_trivial;
    logic                   div_start;
    logic                   div_done;
    logic [WEIGHT_FRAC_BITS-1:0] div_quot;
    logic signed [PW-1:0]   sum;

    assign in_xfer  = item_in.valid && item_in.ready;
    assign out_free = !out_valid_reg || result_out.ready;

    // load path: a position beyond the table is dropped
    assign idx_w  = IW'(item_in.entry_index);
    assign idx_ok = ({1'b0, idx_w} < DEPTH_C);
    assign tbl_wr = in_xfer && (item_in.opcode == OP_LOAD) && idx_ok;

    // a count above the table depth is clamped
    assign eiu_w  = (IW+1)'(entries_reg);
    assign n_full = (eiu_w > DEPTH_C) ? DEPTH_C : eiu_w;

    assign m_sum  = lo_reg + (count_reg >> 1);
    assign lo_dec = lo_reg - 1'b1;
    assign k_inc  = k_reg + 1'b1;

    // probe address in the search, then the two bracketing samples
    always_comb
    begin
        case (state_reg)
            S_SEARCH: rd_addr = m_sum[AW-1:0];
            S_CHECK:  rd_addr = lo_dec[AW-1:0];
            S_RD1:    rd_addr = k_inc[AW-1:0];
            default:  rd_addr = '0;
        endcase
    end

    stli_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VB)
    ) u_x_ram (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (idx_w[AW-1:0]),
        .wr_data (item_in.point_x[VB-1:0]),
        .rd_addr (rd_addr),
        .rd_data (x_rdata)
    );

    stli_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VB)
    ) u_y_ram (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (idx_w[AW-1:0]),
        .wr_data (item_in.point_y[VB-1:0]),
        .rd_addr (rd_addr),
        .rd_data (y_rdata)
    );

    assign x_le = $signed(x_rdata) <= px_reg;

    // unordered samples or a query at or below x0 give weight 0, at or past x1 give 1.0
    assign w_trivial = (dx_reg <= 0) || (num_reg <= 0) || (num_reg >= dx_reg);
    assign div_start = (state_reg == S_WEIGHT) && !w_trivial;

    stli_div #(
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (dx_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // floor shift keeps the result between y0 and y1
    assign sum = PW'(y0_reg) + (prod_reg >>> WEIGHT_FRAC_BITS);

    // controller, output register and configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_index_reg  <= '0;
            out_status_reg <= ST_OK;
            entries_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                entries_reg <= cfg_wr_data;
            end
            // the finish state refills the output register itself
            if (out_valid_reg && result_out.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= (item_in.opcode == OP_LOAD) ? S_FINISH : S_SEARCH;
                    end
                end
                S_SEARCH: state_reg <= (count_reg == '0) ? S_CHECK : S_SWAIT;
                S_SWAIT:  state_reg <= S_SEARCH;
                S_CHECK:
                begin
                    if ((lo_reg == '0) || (lo_reg >= n_reg))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_RD1;
                    end
                end
                S_RD1:    state_reg <= S_RD2;
                S_RD2:    state_reg <= S_WEIGHT;
                S_WEIGHT: state_reg <= w_trivial ? S_MUL : S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:    state_reg <= S_ADD;
                S_ADD:    state_reg <= S_FINISH;
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= res_value_reg;
                        out_index_reg  <= res_index_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    px_reg         <= $signed(item_in.point_x[VB-1:0]);
                    n_reg          <= n_full[IW-1:0];
                    lo_reg         <= '0;
                    count_reg      <= n_full[IW-1:0];
                    res_value_reg  <= '0;
                    res_index_reg  <= '0;
                    res_status_reg <= ST_OK;
                end
            end
            S_SEARCH:
            begin
                m_reg    <= m_sum;
                step_reg <= count_reg >> 1;
            end
            S_SWAIT:
            begin
                if (x_le)
                begin
                    lo_reg    <= m_reg + 1'b1;
                    count_reg <= count_reg - step_reg - 1'b1;
                end
                else
                begin
                    count_reg <= step_reg;
                end
            end
            S_CHECK:
            begin
                k_reg <= lo_dec;
                if (lo_reg == '0)
                begin
                    res_status_reg <= ST_BELOW;
                end
                else if (lo_reg >= n_reg)
                begin
                    res_status_reg <= ST_ABOVE;
                end
            end
            S_RD1:
            begin
                x0_reg <= $signed(x_rdata);
                y0_reg <= $signed(y_rdata);
            end
            S_RD2:
            begin
                dx_reg  <= DW'($signed(x_rdata)) - DW'(x0_reg);
                num_reg <= DW'(px_reg) - DW'(x0_reg);
                dy_reg  <= DW'($signed(y_rdata)) - DW'(y0_reg);
            end
            S_WEIGHT:
            begin
                if ((dx_reg <= 0) || (num_reg <= 0))
                begin
                    w_reg <= '0;
                end
                else if (num_reg >= dx_reg)
                begin
                    w_reg <= WEIGHT_ONE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    w_reg <= {1'b0, div_quot};
                end
            end
            S_MUL:
            begin
                prod_reg <= $signed({1'b0, w_reg}) * dy_reg;
            end
            S_ADD:
            begin
                res_value_reg <= sum[FIELD_BITS-1:0];
                res_index_reg <= k_reg[INDEX_BITS-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign item_in.ready                 = (state_reg == S_IDLE);
    assign result_out.valid              = out_valid_reg;
    assign result_out.interpolated_value = out_value_reg;
    assign result_out.lower_index        = out_index_reg;
    assign result_out.status             = out_status_reg;

    // search window stays inside the searched count
    `STLI_ASSERT_IMPLY(a_search_window, clk, rst_n, (state_reg == S_SEARCH) || (state_reg == S_SWAIT), ((IW+1)'(lo_reg) + (IW+1)'(count_reg)) <= (IW+1)'(n_reg), "search window beyond entry count")
    // upper bracketing sample lies inside the table
    `STLI_ASSERT_NEXT(a_bracket, clk, rst_n, (state_reg == S_CHECK) && (lo_reg != '0) && (lo_reg < n_reg), k_inc < n_reg, "upper sample beyond entry count")
    // quotient only arrives while the controller waits for it
    `STLI_ASSERT_IMPLY(a_div_owner, clk, rst_n, div_done, state_reg == S_DIV, "divider finished outside the divide state")
    // weight never exceeds one
    `STLI_ASSERT_IMPLY(a_weight_max, clk, rst_n, state_reg == S_MUL, w_reg <= WEIGHT_ONE, "weight above one")

endmodule

`default_nettype wire

// ----- sv/stli_ram.sv -----
// simple dual-port sample memory, one write and one registered read per cycle
`default_nettype none

module stli_ram import stli_pkg::*; #(
    parameter int DEPTH = DEF_TABLE_DEPTH,
    parameter int WIDTH = DEF_VALUE_BITS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/stli_div.sv -----
// restoring divider for the interpolation weight, one quotient bit per cycle
`default_nettype none

module stli_div import stli_pkg::*; #(
    parameter int DW = DEF_VALUE_BITS + 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [DW-1:0]               num,
    input  wire logic [DW-1:0]               den,
    output logic                             done,
    output logic [WEIGHT_FRAC_BITS-1:0]      quot
);

    localparam int CNT_BITS = $clog2(WEIGHT_FRAC_BITS + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_BITS-1:0]         cnt_reg;
    logic [DW-1:0]               rem_reg;
    logic [DW-1:0]               den_reg;
    logic [WEIGHT_FRAC_BITS-1:0] quot_reg;

    logic [DW:0] shifted;
    logic        fits;

    // num < den holds, so the remainder always stays below den
    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_BITS'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(WEIGHT_FRAC_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? DW'(shifted - {1'b0, den_reg}) : shifted[DW-1:0];
            quot_reg <= {quot_reg[WEIGHT_FRAC_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- tb/sampled_table_linear_interp_tb.sv -----
// self-checking testbench for the sample table interpolation block
`timescale 1ns / 100ps

module sampled_table_linear_interp_tb import stli_pkg::*; ();

    localparam int          DEPTH         = DEF_TABLE_DEPTH;
    localparam int          RANDOM_ITEMS  = 1500;
    localparam int          MAX_IDLE      = 18;
    localparam int          DRAIN_CYCLES  = 64;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int          REPORT_LIMIT  = 10;

    // extremes of a signed q16.16 field, as bits and as wide integers
    localparam logic [FIELD_BITS-1:0] Q_MIN_BITS = 32'h8000_0000;
    localparam logic [FIELD_BITS-1:0] Q_MAX_BITS = 32'h7FFF_FFFF;
    localparam longint                Q_MIN      = -64'sd2147483648;
    localparam longint                Q_MAX      = 64'sd2147483647;

    typedef struct packed {
        logic                  opcode;
        logic [INDEX_BITS-1:0] entry_index;
        logic [FIELD_BITS-1:0] point_x;
        logic [FIELD_BITS-1:0] point_y;
    } table_item_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] value;
        logic [INDEX_BITS-1:0] lower;
        status_t               status;
    } interp_result_t;

    // a directed row is either one item or an entry-count write
    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        table_item_t           item;
        logic [COUNT_BITS-1:0] count;
        logic                  typed;
        interp_result_t        expected;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [COUNT_BITS-1:0] cfg_wr_data;

    stli_in_if  in_ch ();
    stli_out_if out_ch ();

    sampled_table_linear_interp u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_in     (in_ch),
        .result_out  (out_ch)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    // predictor state: own copy of the sample points and the entry count
    logic signed [FIELD_BITS-1:0] knot_x [DEPTH];
    logic signed [FIELD_BITS-1:0] knot_y [DEPTH];
    logic [COUNT_BITS-1:0]        search_count;

    // results predicted at input transfer, oldest first
    interp_result_t pending_results [$];

    int          mismatch_count  = 0;
    int          results_checked = 0;
    int          loads_sent      = 0;
    int          queries_sent    = 0;
    int          items_sent      = 0;
    int          cfg_writes      = 0;
    int unsigned cycle_count     = 0;

    // stretches with no idling on either side
    bit src_quiet = 1'b0;
    bit snk_quiet = 1'b0;

    // uniform value in [0, span), span at most 2^32
    function automatic longint rand_span(longint span);
        int unsigned u;
        u = $urandom;
        return longint'(u) % span;
    endfunction

    // one item through the predictor: loads update the table copy,
    // queries run the same upper-bound search and weight arithmetic
    function automatic interp_result_t table_interp_step(table_item_t it);
        interp_result_t r;
        longint         n_eff, lo, cnt, half, k, q;
        longint         x0, x1, y0, y1, dx, num, w;
        r = '{value: '0, lower: '0, status: ST_OK};
        if (it.opcode == OP_LOAD)
        begin
            knot_x[it.entry_index] = it.point_x;
            knot_y[it.entry_index] = it.point_y;
            return r;
        end
        q     = longint'($signed(it.point_x));
        // counts beyond the table size search the whole table
        n_eff = (longint'(search_count) > DEPTH) ? DEPTH : longint'(search_count);
        lo    = 0;
        cnt   = n_eff;
        while (cnt > 0)
        begin
            half = cnt / 2;
            if (longint'(knot_x[lo + half]) <= q)
            begin
                lo  = lo + half + 1;
                cnt = cnt - half - 1;
            end
            else
            begin
                cnt = half;
            end
        end
        if (lo == 0)
            r.status = ST_BELOW;
        else if (lo >= n_eff)
            r.status = ST_ABOVE;
        else
        begin
            k   = lo - 1;
            x0  = longint'(knot_x[k]);
            x1  = longint'(knot_x[k + 1]);
            y0  = longint'(knot_y[k]);
            y1  = longint'(knot_y[k + 1]);
            dx  = x1 - x0;
            num = q - x0;
            // unordered points give weight zero, otherwise saturate to [0, 1.0]
            if (dx <= 0 || num <= 0)
                w = 0;
            else if (num >= dx)
                w = longint'(WEIGHT_ONE);
            else
                w = (num <<< WEIGHT_FRAC_BITS) / dx;
            // floor shift keeps the value between y0 and y1
            r.value = FIELD_BITS'(y0 + ((w * (y1 - y0)) >>> WEIGHT_FRAC_BITS));
            r.lower = INDEX_BITS'(k);
        end
        return r;
    endfunction

    function automatic stim_row_t row_cfg(logic [COUNT_BITS-1:0] n);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.count = n;
        return r;
    endfunction

    // loads always answer ok with zero value and index
    function automatic stim_row_t row_load(logic [INDEX_BITS-1:0] idx,
                                           logic [FIELD_BITS-1:0] x,
                                           logic [FIELD_BITS-1:0] y);
        stim_row_t r;
        r          = '0;
        r.kind     = ROW_ITEM;
        r.item     = '{opcode: OP_LOAD, entry_index: idx, point_x: x, point_y: y};
        r.typed    = 1'b1;
        r.expected = '{value: '0, lower: '0, status: ST_OK};
        return r;
    endfunction

    // query checked by the predictor
    function automatic stim_row_t row_query(logic [FIELD_BITS-1:0] x);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.item = '{opcode: OP_QUERY, entry_index: '0, point_x: x,
                   point_y: x ^ 32'h5A5A_5A5A};
        return r;
    endfunction

    // query whose out-of-range status is known up front
    function automatic stim_row_t row_query_flag(logic [FIELD_BITS-1:0] x, status_t st);
        stim_row_t r;
        r          = row_query(x);
        r.typed    = 1'b1;
        r.expected = '{value: '0, lower: '0, status: st};
        return r;
    endfunction

    function automatic logic [FIELD_BITS-1:0] pick_y();
        case ($urandom_range(0, 7))
            0:       return Q_MAX_BITS;
            1:       return Q_MIN_BITS;
            default: return FIELD_BITS'($urandom);
        endcase
    endfunction

    // query x aimed mostly inside a segment, also at sample points,
    // below the first sample, at or above the last, and anywhere
    function automatic logic [FIELD_BITS-1:0] pick_query_x();
        longint n_eff, k, lo, hi, q;
        int     sel;
        n_eff = (longint'(search_count) > DEPTH) ? DEPTH : longint'(search_count);
        sel   = $urandom_range(0, 99);
        if (n_eff == 0 || sel >= 86)
            return FIELD_BITS'($urandom);
        if (sel < 60 && n_eff >= 2)
        begin
            k  = $urandom_range(0, n_eff - 2);
            lo = longint'(knot_x[k]);
            hi = longint'(knot_x[k + 1]);
            q  = (hi > lo) ? lo + rand_span(hi - lo + 1) : lo;
        end
        else if (sel < 70)
            q = longint'(knot_x[$urandom_range(0, n_eff - 1)]);
        else if (sel < 78)
        begin
            lo = longint'(knot_x[0]);
            q  = (lo > Q_MIN) ? Q_MIN + rand_span(lo - Q_MIN) : Q_MIN;
        end
        else
        begin
            hi = longint'(knot_x[n_eff - 1]);
            q  = hi + rand_span(Q_MAX - hi + 1);
        end
        return FIELD_BITS'(q);
    endfunction

    // present one item after a random gap and wait for its transfer;
    // valid stays high afterwards so a back-to-back item needs no drop
    task automatic send_item(input table_item_t it, input logic typed,
                             input interp_result_t typed_res);
        int             gap;
        interp_result_t predicted;
        interp_result_t want_res;
        gap = src_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if ($urandom_range(0, 39) == 0)
            src_quiet = ~src_quiet;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= it.opcode;
        in_ch.entry_index <= it.entry_index;
        in_ch.point_x     <= it.point_x;
        in_ch.point_y     <= it.point_y;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // transfer at this edge: predict in transfer order
        predicted       = table_interp_step(it);
        want_res        = typed ? typed_res : predicted;
        pending_results = {pending_results, want_res};
        items_sent++;
        if (it.opcode == OP_LOAD)
            loads_sent++;
        else
            queries_sent++;
    endtask

    // entry count changes only once the block has drained
    task automatic write_entry_count(input logic [COUNT_BITS-1:0] n);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        search_count  = n;
        cfg_writes++;
    endtask

    // load entries 0..n-1, ascending x with a random step size or fully random
    task automatic fill_knots(input int n, input bit ordered);
        longint      maxinc, slack, cur;
        bit          pin_top;
        table_item_t it;
        case ($urandom_range(0, 3))
            0:       maxinc = 3;
            1:       maxinc = 65536;
            2:       maxinc = 64'd1 << 22;
            default: maxinc = 64'hFFFF_FFFF / n;
        endcase
        slack = 64'hFFFF_FFFF - longint'(n - 1) * maxinc;
        if (slack < 0)
            slack = 0;
        cur     = Q_MIN + (($urandom_range(0, 3) == 0) ? 0 : rand_span(slack + 1));
        pin_top = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            it.opcode      = OP_LOAD;
            it.entry_index = INDEX_BITS'(i);
            it.point_y     = pick_y();
            if (!ordered)
                it.point_x = FIELD_BITS'($urandom);
            else if (pin_top && i == n - 1)
                it.point_x = Q_MAX_BITS;
            else
                it.point_x = FIELD_BITS'(cur);
            cur = cur + rand_span(maxinc + 1);
            if (cur > Q_MAX)
                cur = Q_MAX;
            send_item(it, 1'b0, '0);
        end
    endtask

    // queries with some stray loads mixed in, which may break the ordering
    task automatic run_queries(input int count);
        table_item_t it;
        for (int i = 0; i < count; i++)
        begin
            it.entry_index = INDEX_BITS'($urandom);
            it.point_y     = pick_y();
            if ($urandom_range(0, 14) == 0)
            begin
                it.opcode  = OP_LOAD;
                it.point_x = FIELD_BITS'($urandom);
            end
            else
            begin
                it.opcode  = OP_QUERY;
                it.point_x = pick_query_x();
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // run length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, every result transfer checked against the oldest expectation
    initial
    begin
        int             stall;
        interp_result_t got;
        interp_result_t want;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = snk_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if ($urandom_range(0, 39) == 0)
                snk_quiet = ~snk_quiet;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            got = '{value: out_ch.interpolated_value, lower: out_ch.lower_index,
                    status: status_t'(out_ch.status)};
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result: value %h lower_index %0d status %0d",
                             got.value, got.lower, got.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.value !== want.value || got.lower !== want.lower ||
                    got.status !== want.status)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("mismatch on result %0d: value exp %h got %h, %s %0d got %0d, %s %0d got %0d",
                                 results_checked, want.value, got.value,
                                 "lower_index exp", want.lower, got.lower,
                                 "status exp", want.status, got.status);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus: directed rows, a full-depth table, then many small tables
    initial
    begin
        stim_row_t directed_rows [$];
        int        random_start;
        int        n;
        int        fail_count;

        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OP_LOAD;
        in_ch.entry_index <= '0;
        in_ch.point_x     <= '0;
        in_ch.point_y     <= '0;
        search_count       = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // table x: min, 0, 1.0, 1.0 (repeated x), max; entry 1023 written but never searched
        directed_rows = '{
            row_query_flag(32'h0000_0000, ST_BELOW),   // empty table after reset
            row_query_flag(Q_MIN_BITS, ST_BELOW),
            row_load(10'd0, Q_MIN_BITS, Q_MAX_BITS),
            row_load(10'd1, 32'h0000_0000, Q_MIN_BITS),
            row_load(10'd2, 32'h0001_0000, 32'h0001_0000),
            row_load(10'd3, 32'h0001_0000, 32'h0005_0000),
            row_load(10'd4, Q_MAX_BITS, 32'hFFFF_FFFF),
            row_load(10'd1023, 32'h1234_5678, 32'hA5A5_A5A5),
            row_cfg(11'd1),
            // single entry: every query lands at or above it
            row_query_flag(Q_MIN_BITS, ST_ABOVE),
            row_query_flag(Q_MAX_BITS, ST_ABOVE),
            row_cfg(11'd5),
            row_query(Q_MIN_BITS),                      // exactly on the first sample
            row_query_flag(Q_MAX_BITS, ST_ABOVE),       // exactly on the last sample
            row_query(32'hC000_0000),                   // widest segment, widest y swing
            row_query(32'h0000_8000),
            row_query(32'h0001_0000),                   // repeated x
            row_query(32'h0000_FFFF),
            row_query(32'h7FFF_FFFE),
            row_query(32'hFFFF_FFFF),
            // first entry moved above the second: table no longer ordered
            row_load(10'd0, 32'h0000_0100, 32'h0000_0000),
            row_query_flag(Q_MIN_BITS, ST_BELOW),
            row_query(32'h0000_0000),
            row_query(32'h0000_0100),
            row_cfg(11'd0),
            row_query_flag(Q_MAX_BITS, ST_BELOW),
            row_cfg(11'd2),
            row_query(32'h0000_0080),
            row_query(32'hFFFF_FF00)
        };
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_entry_count(directed_rows[i].count);
            else
                send_item(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].expected);
        end

        random_start = items_sent;

        // full table, searched at full depth, at an oversize count and one short
        fill_knots(DEPTH, 1'b1);
        write_entry_count(COUNT_BITS'(DEPTH));
        run_queries(40);
        write_entry_count({COUNT_BITS{1'b1}});
        run_queries(40);
        write_entry_count(COUNT_BITS'(DEPTH - 1));
        run_queries(15);

        // small tables, mostly ordered; every entry is loaded, so any count is legal
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    n = $urandom_range(0, (1 << COUNT_BITS) - 1);
                end
                1:
                begin
                    n = $urandom_range(0, 2);
                    if (n > 0)
                        fill_knots(n, 1'b1);
                end
                default:
                begin
                    n = $urandom_range(3, 48);
                    fill_knots(n, $urandom_range(0, 6) != 0);
                end
            endcase
            write_entry_count(COUNT_BITS'(n));
            run_queries($urandom_range(10, 30));
        end

        // drain, then watch for stray results
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        fail_count = mismatch_count + pending_results.size();
        $display("ran %0d loads and %0d queries over %0d entry-count settings",
                 loads_sent, queries_sent, cfg_writes);
        $display("compared %0d results, %0d failures", results_checked, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sampled_table_linear_interp.f -----
+incdir+sv
sv/stli_pkg.sv
sv/stli_if.sv
sv/stli_ram.sv
sv/stli_div.sv
sv/sampled_table_linear_interp.sv
tb/sampled_table_linear_interp_tb.sv
